FILE: sv/sida_pkg.sv
package sida_pkg;

	localparam int VALUE_BITS_DEF = 32;
	localparam int PC_BITS = 3;

	localparam logic [7:0] CHAR_ZERO  = 8'h30;
	localparam logic [7:0] CHAR_MINUS = 8'h2d;

	// decimal digits for the largest magnitude, 2^(vb-1); never too few
	function automatic int digits_for(input int vb);
		return ((vb * 1233) >> 12) + 1;
	endfunction

	typedef enum logic [2:0] {
		C_ALWAYS,
		C_NO_INPUT,
		C_MORE_BITS,
		C_POSITIVE,
		C_OUT_BUSY,
		C_LEAD_ZERO,
		C_EMIT_AGAIN
	} cond_t;

	typedef struct packed {
		logic load;
		logic dabble;
		logic emit_sign;
		logic skip;
		logic emit_digit;
	} ctrl_t;

	typedef struct packed {
		ctrl_t              act;
		cond_t              cond;
		logic [PC_BITS-1:0] target;
	} uword_t;

	typedef struct packed {
		logic out_busy;
		logic more_bits;
		logic neg;
		logic lead_zero;
		logic more_digits;
	} status_t;

endpackage

FILE: sv/sida_seq.sv
module sida_seq
	import sida_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    in_valid,
	input  status_t stat,
	output logic    in_ready,
	output ctrl_t   ctrl
);

	localparam logic [PC_BITS-1:0] S_LOAD   = PC_BITS'(0);
	localparam logic [PC_BITS-1:0] S_DABBLE = PC_BITS'(1);
	localparam logic [PC_BITS-1:0] S_BRANCH = PC_BITS'(2);
	localparam logic [PC_BITS-1:0] S_SIGN   = PC_BITS'(3);
	localparam logic [PC_BITS-1:0] S_SKIP   = PC_BITS'(4);
	localparam logic [PC_BITS-1:0] S_DIGIT  = PC_BITS'(5);
	localparam logic [PC_BITS-1:0] S_RETURN = PC_BITS'(6);

	localparam ctrl_t A_NONE  = '{default: 1'b0};
	localparam ctrl_t A_LOAD  = '{load: 1'b1, default: 1'b0};
	localparam ctrl_t A_DAB   = '{dabble: 1'b1, default: 1'b0};
	localparam ctrl_t A_SIGN  = '{emit_sign: 1'b1, default: 1'b0};
	localparam ctrl_t A_SKIP  = '{skip: 1'b1, default: 1'b0};
	localparam ctrl_t A_DIGIT = '{emit_digit: 1'b1, default: 1'b0};

	function automatic uword_t ucode(input logic [PC_BITS-1:0] pc);
		uword_t w;
		case (pc)
			S_LOAD:   w = '{act: A_LOAD,  cond: C_NO_INPUT,   target: S_LOAD};
			S_DABBLE: w = '{act: A_DAB,   cond: C_MORE_BITS,  target: S_DABBLE};
			S_BRANCH: w = '{act: A_NONE,  cond: C_POSITIVE,   target: S_SKIP};
			S_SIGN:   w = '{act: A_SIGN,  cond: C_OUT_BUSY,   target: S_SIGN};
			S_SKIP:   w = '{act: A_SKIP,  cond: C_LEAD_ZERO,  target: S_SKIP};
			S_DIGIT:  w = '{act: A_DIGIT, cond: C_EMIT_AGAIN, target: S_DIGIT};
			S_RETURN: w = '{act: A_NONE,  cond: C_ALWAYS,     target: S_LOAD};
			default:  w = '{act: A_NONE,  cond: C_ALWAYS,     target: S_LOAD};
		endcase
		return w;
	endfunction

	logic [PC_BITS-1:0] pc_q;
	uword_t             uw;
	logic               take;

	assign uw = ucode(pc_q);

	always_comb begin
		case (uw.cond)
			C_ALWAYS:     take = 1'b1;
			C_NO_INPUT:   take = !in_valid;
			C_MORE_BITS:  take = stat.more_bits;
			C_POSITIVE:   take = !stat.neg;
			C_OUT_BUSY:   take = stat.out_busy;
			C_LEAD_ZERO:  take = stat.lead_zero;
			C_EMIT_AGAIN: take = stat.out_busy || stat.more_digits;
			default:      take = 1'b1;
		endcase
	end

	assign in_ready = uw.act.load;

	// actions only fire when their step really completes
	always_comb begin
		ctrl            = uw.act;
		ctrl.load       = uw.act.load & in_valid;
		ctrl.emit_sign  = uw.act.emit_sign & !stat.out_busy;
		ctrl.skip       = uw.act.skip & stat.lead_zero;
		ctrl.emit_digit = uw.act.emit_digit & !stat.out_busy;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q <= S_LOAD;
		end else if (take) begin
			pc_q <= uw.target;
		end else begin
			pc_q <= pc_q + PC_BITS'(1);
		end
	end

endmodule

FILE: sv/sida_dp.sv
module sida_dp
	import sida_pkg::*;
#(
	parameter int VALUE_BITS = VALUE_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic [VALUE_BITS-1:0] value,
	input  ctrl_t                 ctrl,
	input  logic                  out_ready,
	output status_t               stat,
	output logic                  out_valid,
	output logic [7:0]            character,
	output logic                  last
);

	localparam int ND     = digits_for(VALUE_BITS);
	localparam int BCD_W  = 4 * ND;
	localparam int BCNT_W = $clog2(VALUE_BITS);
	localparam int DCNT_W = $clog2(ND + 1);

	logic [VALUE_BITS-1:0] mag_q;
	logic [BCD_W-1:0]      bcd_q;
	logic [BCD_W-1:0]      bcd_adj;
	logic [BCNT_W-1:0]     bcnt_q;
	logic [DCNT_W-1:0]     dcnt_q;
	logic                  neg_q;
	logic                  out_valid_q;
	logic [7:0]            char_q;
	logic                  last_q;
	logic [3:0]            top_digit;
	logic                  emit;

	// add 3 to every digit of 5 or more before the shift
	always_comb begin
		for (int i = 0; i < ND; i++) begin
			if (bcd_q[4*i +: 4] >= 4'd5) begin
				bcd_adj[4*i +: 4] = bcd_q[4*i +: 4] + 4'd3;
			end else begin
				bcd_adj[4*i +: 4] = bcd_q[4*i +: 4];
			end
		end
	end

	assign top_digit = bcd_q[BCD_W-1 -: 4];
	assign emit      = ctrl.emit_sign | ctrl.emit_digit;

	assign stat.out_busy    = out_valid_q && !out_ready;
	assign stat.more_bits   = bcnt_q != '0;
	assign stat.neg         = neg_q;
	assign stat.lead_zero   = (top_digit == 4'd0) && (dcnt_q != DCNT_W'(1));
	assign stat.more_digits = dcnt_q != DCNT_W'(1);

	always_ff @(posedge clk) begin
		if (ctrl.load) begin
			mag_q <= value[VALUE_BITS-1] ? (~value + VALUE_BITS'(1)) : value;
			bcd_q <= '0;
		end else if (ctrl.dabble) begin
			mag_q <= {mag_q[VALUE_BITS-2:0], 1'b0};
			bcd_q <= {bcd_adj[BCD_W-2:0], mag_q[VALUE_BITS-1]};
		end else if (ctrl.skip || ctrl.emit_digit) begin
			bcd_q <= {bcd_q[BCD_W-5:0], 4'd0};
		end
		if (ctrl.emit_sign) begin
			char_q <= CHAR_MINUS;
			last_q <= 1'b0;
		end else if (ctrl.emit_digit) begin
			char_q <= CHAR_ZERO | {4'd0, top_digit};
			last_q <= dcnt_q == DCNT_W'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bcnt_q      <= '0;
			dcnt_q      <= '0;
			neg_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (ctrl.load) begin
				bcnt_q <= BCNT_W'(VALUE_BITS - 1);
				dcnt_q <= DCNT_W'(ND);
				neg_q  <= value[VALUE_BITS-1];
			end else begin
				if (ctrl.dabble && bcnt_q != '0) begin
					bcnt_q <= bcnt_q - BCNT_W'(1);
				end
				if (ctrl.skip || ctrl.emit_digit) begin
					dcnt_q <= dcnt_q - DCNT_W'(1);
				end
			end
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign character = char_q;
	assign last      = last_q;

endmodule

FILE: sv/signed_int_to_decimal_ascii.sv
// channel  direction  tdata (low bit up)                 tlast
// s_axis   in         value [VALUE_BITS-1:0], zero pad    -
// m_axis   out        character [7:0]                     last character of the number
//
// one number passes the idle step, the bit-serial bcd shift loop, a sign branch, a minus
// sign step when negative, the leading zero skip and the digit emit over ND digits, where ND
// is the digit capacity (10 at 32 bits), and a return step to idle.
// the shift loop takes one bit per cycle and the single output register gives one character
// per cycle while m_axis_tready holds high; a new number is taken only at the idle step.
// arst_n clears the step counter and the output valid; m_axis_tready low stalls the
// sequencer on its emit step with the word held.
module signed_int_to_decimal_ascii
	import sida_pkg::*;
#(
	parameter int VALUE_BITS = VALUE_BITS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_axis_tvalid,
	output logic                                s_axis_tready,
	input  logic [((VALUE_BITS + 7) / 8)*8-1:0] s_axis_tdata,  // value
	output logic                                m_axis_tvalid,
	input  logic                                m_axis_tready,
	output logic [7:0]                          m_axis_tdata,  // character
	output logic                                m_axis_tlast
);

	ctrl_t   ctrl;
	status_t stat;

	sida_seq u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.stat     (stat),
		.in_ready (s_axis_tready),
		.ctrl     (ctrl)
	);

	sida_dp #(
		.VALUE_BITS (VALUE_BITS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.value     (s_axis_tdata[VALUE_BITS-1:0]),
		.ctrl      (ctrl),
		.out_ready (m_axis_tready),
		.stat      (stat),
		.out_valid (m_axis_tvalid),
		.character (m_axis_tdata),
		.last      (m_axis_tlast)
	);

	// only a minus sign or a decimal digit ever leaves
	a_char_legal: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (m_axis_tdata == CHAR_MINUS) ||
		((m_axis_tdata >= CHAR_ZERO) && (m_axis_tdata <= CHAR_ZERO + 8'd9)))
		else $error("illegal output character");

	// a minus sign is never the end of a number
	a_sign_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && (m_axis_tdata == CHAR_MINUS) |-> !m_axis_tlast)
		else $error("minus sign marked last");

	// the converter is busy right after taking a word
	a_busy_after_load: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
		else $error("input taken during conversion");

endmodule

FILE: verif/tb_signed_int_to_decimal_ascii.sv
`timescale 1ns / 100ps

module tb_signed_int_to_decimal_ascii;
	import sida_pkg::*;

	localparam int VB          = VALUE_BITS_DEF;
	localparam int TDATA_W     = ((VB + 7) / 8) * 8;
	localparam int HOLD_CYCLES = 300;
	localparam int DRAIN_WAIT  = 60;

	typedef enum {SINK_RANDOM, SINK_OPEN, SINK_HOLD} sink_mode_t;
	typedef enum {SRC_RANDOM, SRC_BACK_TO_BACK} src_mode_t;

	// text of each accepted number, one entry per character, oldest first
	class digit_text_board;
		typedef struct {
			logic [7:0] ch;
			logic       fin;
		} char_entry_t;

		char_entry_t pending[$];
		int mismatches;
		int numbers_noted;
		int negatives_noted;
		int ten_digit_noted;
		int chars_checked;

		function void note_number(logic [VB-1:0] value);
			logic       neg;
			logic [VB-1:0] mag;
			logic [7:0] text[$];
			char_entry_t e;
			int ndig;
			neg = value[VB-1];
			// negating the most negative value leaves 2^(VB-1), read unsigned
			mag = neg ? (~value + 1'b1) : value;
			ndig = 0;
			do begin
				text.push_front(CHAR_ZERO + 8'(mag % 10));
				mag = mag / 10;
				ndig++;
			end while (mag != 0);
			if (neg)
				text.push_front(CHAR_MINUS);
			for (int i = 0; i < text.size(); i++) begin
				e.ch  = text[i];
				e.fin = (i == text.size() - 1);
				pending.push_back(e);
			end
			numbers_noted++;
			if (neg)
				negatives_noted++;
			if (ndig == 10)
				ten_digit_noted++;
		endfunction

		function void check_char(logic [7:0] ch, logic fin);
			char_entry_t e;
			chars_checked++;
			if (pending.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected character 0x%02h last=%0b, nothing pending", ch, fin);
				return;
			end
			e = pending.pop_front();
			if (ch !== e.ch || fin !== e.fin) begin
				mismatches++;
				if (mismatches <= 10)
					$display("character mismatch: want 0x%02h last=%0b, got 0x%02h last=%0b",
						e.ch, e.fin, ch, fin);
			end
		endfunction
	endclass

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               s_axis_tvalid = 1'b0;
	logic               s_axis_tready;
	logic [TDATA_W-1:0] s_axis_tdata = '0;   // value
	logic               m_axis_tvalid;
	logic               m_axis_tready = 1'b0;
	logic [7:0]         m_axis_tdata;        // character
	logic               m_axis_tlast;

	digit_text_board board = new();
	sink_mode_t      sink_mode = SINK_OPEN;
	src_mode_t       src_mode = SRC_BACK_TO_BACK;
	int              longest_hold = 0;

	signed_int_to_decimal_ascii #(
		.VALUE_BITS(VB)
	) DUT (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast)
	);

	initial begin
		forever #6 clk = ~clk;
	end

	initial begin
		#40_000_000;
		$display("tb: failure");
		$finish;
	end

	function automatic int pick_gap();
		int r;
		if (src_mode == SRC_BACK_TO_BACK)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		else if (r < 92)
			return $urandom_range(1, 3);
		else
			return $urandom_range(10, 60);
	endfunction

	// mostly numbers of a chosen digit count, some raw 32-bit patterns
	function automatic logic [VB-1:0] random_number();
		longint lo;
		longint hi;
		longint mag;
		int n;
		if ($urandom_range(0, 9) < 3)
			return VB'($urandom());
		n  = $urandom_range(1, 10);
		lo = (n == 1) ? 0 : 1;
		hi = 9;
		for (int i = 1; i < n; i++) begin
			lo = lo * 10;
			hi = hi * 10 + 9;
		end
		if (hi > 64'sd2147483647)
			hi = 64'sd2147483647;
		mag = lo + longint'($urandom_range(0, int'(hi - lo)));
		if ($urandom_range(0, 1))
			mag = -mag;
		return VB'(mag);
	endfunction

	// called at a rising edge; returns at the edge where the word was taken
	task automatic send_number(input logic [VB-1:0] value);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= TDATA_W'(value);
		do @(posedge clk); while (!s_axis_tready);
		board.note_number(value);
	endtask

	// output side: checks every taken character and drives tready
	initial begin
		int hold_left;
		int hold_count;
		logic level;
		hold_left  = 0;
		hold_count = 0;
		level      = 1'b1;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (m_axis_tvalid && m_axis_tready)
				board.check_char(m_axis_tdata, m_axis_tlast);
			case (sink_mode)
				SINK_OPEN: begin
					m_axis_tready <= 1'b1;
				end
				SINK_HOLD: begin
					m_axis_tready <= 1'b0;
					hold_count++;
					if (hold_count >= HOLD_CYCLES) begin
						longest_hold = hold_count;
						hold_count   = 0;
						hold_left    = 0;
						sink_mode    = SINK_RANDOM;
					end
				end
				default: begin
					if (hold_left == 0) begin
						int r;
						r = $urandom_range(0, 99);
						if (r < 55) begin
							level     = 1'b1;
							hold_left = $urandom_range(1, 12);
						end else if (r < 92) begin
							level     = 1'b0;
							hold_left = $urandom_range(1, 3);
						end else begin
							level     = 1'b0;
							hold_left = $urandom_range(15, 60);
						end
					end
					m_axis_tready <= level;
					hold_left--;
				end
			endcase
		end
	end

	initial begin
		logic [VB-1:0] edge_values[$];
		int leftover;
		edge_values = '{
			32'd0, 32'd1, 32'hffff_ffff, 32'd9, 32'd10, -32'sd10, 32'd99, 32'd100,
			-32'sd5, 32'd999_999_999, 32'd1_000_000_000, -32'sd999_999_999,
			-32'sd1_000_000_000, 32'h7fff_ffff, 32'h8000_0000, 32'h8000_0001,
			32'd1_234_567_890, -32'sd1_234_567_890, 32'hffff_fff6, 32'd2_000_000_000
		};

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		// directed part, receiver always ready and words back to back
		foreach (edge_values[i])
			send_number(edge_values[i]);

		sink_mode = SINK_RANDOM;
		src_mode  = SRC_RANDOM;
		for (int i = 0; i < 200; i++)
			send_number(random_number());

		// stretch with no idling on either side
		sink_mode = SINK_OPEN;
		src_mode  = SRC_BACK_TO_BACK;
		for (int i = 0; i < 60; i++)
			send_number(random_number());

		// long output stall while input keeps offering words
		sink_mode = SINK_HOLD;
		for (int i = 0; i < 6; i++)
			send_number(random_number());

		src_mode = SRC_RANDOM;
		for (int i = 0; i < 145; i++)
			send_number(random_number());
		s_axis_tvalid <= 1'b0;

		while (board.pending.size() != 0)
			@(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);

		leftover = board.pending.size();
		$display("converted %0d numbers into %0d characters: %0d negative, %0d ten digits long",
			board.numbers_noted, board.chars_checked, board.negatives_noted,
			board.ten_digit_noted);
		$display("output held off for %0d cycles once, %0d mismatches",
			longest_hold, board.mismatches);
		if (board.mismatches == 0 && leftover == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
